[src/pbsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsc_pkg: shared types and constants
// Widths, register indices, action and confidence codes, and the channel and
// unit command types used by the price band stability controller.
// ----------------------------------------------------------------------------
package pbsc_pkg;

   localparam int PRICE_WIDTH     = 40;
   localparam int ALPHA_FRAC_BITS = 16;
   localparam int ALPHA_WIDTH     = ALPHA_FRAC_BITS + 1;
   localparam int CSR_DATA_WIDTH  = 40;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int DEV_WIDTH       = 21;
   localparam int ADJ_WIDTH       = 15;
   localparam int CONF_WIDTH      = 7;
   localparam int ACTION_WIDTH    = 3;

   // Division scratch width: dividend of d*10000 fits PRICE_WIDTH + 14 bits.
   localparam int DIV_WIDTH       = PRICE_WIDTH + 15;
   localparam int DIV_CNT_WIDTH   = $clog2(DIV_WIDTH + 1);

   localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE =
      ALPHA_WIDTH'(1) << ALPHA_FRAC_BITS;
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_MIN =
      ALPHA_WIDTH'(((1 << ALPHA_FRAC_BITS) + 999) / 1000);

   localparam logic [DEV_WIDTH-1:0] DEV_SAT = DEV_WIDTH'(1000000);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAND      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ADJ   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EMERGENCY = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA     = 3'd4;

   localparam logic [ACTION_WIDTH-1:0] ACT_NONE         = 3'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_EXPAND       = 3'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_CONTRACT     = 3'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_EMERG_EXPAND = 3'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_EMERG_CONTR  = 3'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_PAUSE        = 3'd5;

   localparam logic [CONF_WIDTH-1:0] CONF_MISSING    = 7'd0;
   localparam logic [CONF_WIDTH-1:0] CONF_UNRELIABLE = 7'd30;
   localparam logic [CONF_WIDTH-1:0] CONF_ADJUST     = 7'd80;
   localparam logic [CONF_WIDTH-1:0] CONF_EMERGENCY  = 7'd90;
   localparam logic [CONF_WIDTH-1:0] CONF_NONE       = 7'd100;

   localparam logic [15:0] SPREAD_LIMIT   = 16'd200;
   localparam logic [6:0]  CONF_THRESHOLD = 7'd70;
   localparam logic [7:0]  SOURCE_MIN     = 8'd3;

   typedef struct packed {
      logic                   func;
      logic [PRICE_WIDTH-1:0] price;
      logic [15:0]            spread_bps;
      logic [6:0]             avg_confidence;
      logic [7:0]             source_count;
   } req_type;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic [ADJ_WIDTH-1:0]    adjust_bps;
      logic [DEV_WIDTH-1:0]    deviation_bps;
      logic [CONF_WIDTH-1:0]   confidence;
      logic [PRICE_WIDTH-1:0]  smoothed_price;
   } rsp_type;

   // Command and status between the sequencer and the serial divider.
   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [DIV_WIDTH-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
   } div_sts_type;

   // Command and status between the sequencer and the serial multiplier.
   typedef struct packed {
      logic                   start;
      logic [PRICE_WIDTH-1:0] mcand;
      logic [ALPHA_WIDTH-1:0] mplier;
   } mul_cmd_type;

   typedef struct packed {
      logic                                 done;
      logic [PRICE_WIDTH+ALPHA_WIDTH-1:0]   product;
   } mul_sts_type;

endpackage : pbsc_pkg
`default_nettype wire

[src/pbsc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsc_req_if / pbsc_rsp_if: valid/ready channels
// Carry one request or one decision beat with its payload.
// ----------------------------------------------------------------------------
interface pbsc_req_if;
   logic               valid;
   logic               ready;
   pbsc_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface : pbsc_req_if

interface pbsc_rsp_if;
   logic               valid;
   logic               ready;
   pbsc_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface : pbsc_rsp_if
`default_nettype wire

[src/pbsc_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsc_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle, least significant first.
// ----------------------------------------------------------------------------
module pbsc_mul (
   input  wire                      clock,
   input  wire                      reset,
   input  pbsc_pkg::mul_cmd_type    cmd,
   output pbsc_pkg::mul_sts_type    sts
);
   localparam int PW = pbsc_pkg::PRICE_WIDTH + pbsc_pkg::ALPHA_WIDTH;
   localparam int CW = $clog2(pbsc_pkg::ALPHA_WIDTH + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] mcand_ff, mcand_in;
   logic [pbsc_pkg::ALPHA_WIDTH-1:0] mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         cnt_in    = CW'(pbsc_pkg::ALPHA_WIDTH);
         acc_in    = '0;
         mcand_in  = PW'(cmd.mcand);
         mplier_in = cmd.mplier;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign sts.done    = done_ff;
   assign sts.product = acc_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("product done without work");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("multiplier busy when done");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("multiplier count underflow");

endmodule : pbsc_mul
`default_nettype wire

[src/pbsc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsc_div: restoring radix-2 divider
// Produces one quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module pbsc_div (
   input  wire                      clock,
   input  wire                      reset,
   input  pbsc_pkg::div_cmd_type    cmd,
   output pbsc_pkg::div_sts_type    sts
);
   localparam int DW = pbsc_pkg::DIV_WIDTH;
   localparam int CW = pbsc_pkg::DIV_CNT_WIDTH;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [DW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         rem_in  = '0;
         quo_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         // The quotient register doubles as the dividend shift line.
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DW'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("quotient done without work");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !$past(cmd.start)) |-> rem_ff < dsr_ff || dsr_ff == '0)
      else $error("remainder not reduced");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider count underflow");

endmodule : pbsc_div
`default_nettype wire

[src/price_band_stability_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// price_band_stability_controller: smoothed price band decisions
// Smooths each price beat, tracks quote quality and emits one decision.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  req_bus  | in        | func, price, spread_bps, avg_confidence, source_count
//  rsp_bus  | out       | action, adjust_bps, deviation_bps, confidence, smoothed_price
//  csr_     | in        | write enable, index, data (no handshake)
//
// A decision beat follows its request beat after two serial multiplies for the
// blend (skipped on the first sample), then a serial division for the deviation
// and another for the adjustment, each skipped on pause or where not needed.
// A new request beat is taken only once the previous decision has been handed
// to the output register and the sequencer is idle again.
// Reset is synchronous and restores register defaults and clears the EMA.
// A decision waits in the output register under backpressure; the next one is
// held in a staging register until that register is free or is being drained.
// ----------------------------------------------------------------------------
module price_band_stability_controller (
   input  wire                                     clock,
   input  wire                                     reset,
   pbsc_req_if.sink                                req_bus,
   pbsc_rsp_if.source                              rsp_bus,
   input  wire                                     csr_we,
   input  wire [pbsc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire [pbsc_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   localparam int PW = pbsc_pkg::PRICE_WIDTH;
   localparam int AW = pbsc_pkg::ALPHA_WIDTH;
   localparam int DW = pbsc_pkg::DIV_WIDTH;
   localparam int MW = PW + AW;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MULA  = 4'd1;
   localparam logic [3:0] ST_WAITA = 4'd2;
   localparam logic [3:0] ST_WAITB = 4'd3;
   localparam logic [3:0] ST_DEV   = 4'd4;
   localparam logic [3:0] ST_WDEV  = 4'd5;
   localparam logic [3:0] ST_DECIDE= 4'd6;
   localparam logic [3:0] ST_WADJ  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   // Configuration registers.
   logic [PW-1:0] target_ff;
   logic [6:0]    band_ff;
   logic [13:0]   max_adj_ff;
   logic [6:0]    emerg_ff;
   logic [AW-1:0] alpha_ff;

   logic [3:0]    state_ff, state_in;
   logic [PW-1:0] ema_ff, ema_in;
   logic          ema_valid_ff, ema_valid_in;
   logic          seen_ff, seen_in;
   logic          reliable_ff, reliable_in;
   logic [PW-1:0] price_ff, price_in;
   logic [AW-1:0] a_ff, a_in;
   logic [MW-1:0] part_ff, part_in;
   logic          neg_ff, neg_in;
   logic [20:0]   mag_ff, mag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pbsc_pkg::rsp_type dec_ff, dec_in;
   pbsc_pkg::rsp_type rsp_ff, rsp_in;

   pbsc_pkg::mul_cmd_type mul_cmd;
   pbsc_pkg::mul_sts_type mul_sts;
   pbsc_pkg::div_cmd_type div_cmd;
   pbsc_pkg::div_sts_type div_sts;

   logic          req_fire;
   logic          out_free;
   logic [AW-1:0] a_clamp;
   logic [MW-1:0] blend_sum;
   logic [PW-1:0] abs_dev;
   logic [13:0]   band_bps;
   logic [13:0]   emerg_bps;
   logic          quote_ok;

   pbsc_mul u_mul (.clock(clock), .reset(reset), .cmd(mul_cmd), .sts(mul_sts));
   pbsc_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .sts(div_sts));

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= PW'(100000);
         band_ff    <= 7'd5;
         max_adj_ff <= 14'd100;
         emerg_ff   <= 7'd20;
         alpha_ff   <= AW'(6554);
      end else if (csr_we) begin
         case (csr_index)
            pbsc_pkg::CSR_TARGET:    target_ff  <= csr_data[PW-1:0];
            pbsc_pkg::CSR_BAND:      band_ff    <= csr_data[6:0];
            pbsc_pkg::CSR_MAX_ADJ:   max_adj_ff <= csr_data[13:0];
            pbsc_pkg::CSR_EMERGENCY: emerg_ff   <= csr_data[6:0];
            pbsc_pkg::CSR_ALPHA:     alpha_ff   <= csr_data[AW-1:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   assign a_clamp   = (alpha_ff < pbsc_pkg::ALPHA_MIN) ? pbsc_pkg::ALPHA_MIN :
                      (alpha_ff > pbsc_pkg::ALPHA_ONE) ? pbsc_pkg::ALPHA_ONE : alpha_ff;
   assign blend_sum = part_ff + mul_sts.product;
   assign abs_dev   = neg_ff ? (target_ff - ema_ff) : (ema_ff - target_ff);
   assign band_bps  = 14'(band_ff) * 14'd100;
   assign emerg_bps = 14'(emerg_ff) * 14'd100;
   assign quote_ok  = (req_bus.payload.spread_bps < pbsc_pkg::SPREAD_LIMIT) &&
                      (req_bus.payload.avg_confidence >= pbsc_pkg::CONF_THRESHOLD) &&
                      (req_bus.payload.source_count >= pbsc_pkg::SOURCE_MIN);

   always_comb begin
      state_in     = state_ff;
      ema_in       = ema_ff;
      ema_valid_in = ema_valid_ff;
      seen_in      = seen_ff;
      reliable_in  = reliable_ff;
      price_in     = price_ff;
      a_in         = a_ff;
      part_in      = part_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      dec_in       = dec_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mul_cmd      = '{start: 1'b0, mcand: price_ff, mplier: a_ff};
      div_cmd      = '{start: 1'b0, dividend: '0, divisor: '0};
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               price_in = req_bus.payload.price;
               a_in     = a_clamp;
               if (req_bus.payload.func) begin
                  seen_in     = 1'b1;
                  reliable_in = quote_ok;
               end
               if (!ema_valid_ff) begin
                  ema_in       = req_bus.payload.price;
                  ema_valid_in = 1'b1;
                  state_in     = ST_DEV;
               end else begin
                  state_in = ST_MULA;
               end
            end
         end
         ST_MULA: begin
            mul_cmd.start = 1'b1;
            state_in      = ST_WAITA;
         end
         ST_WAITA: begin
            if (mul_sts.done) begin
               part_in       = mul_sts.product;
               mul_cmd.start = 1'b1;
               mul_cmd.mcand = ema_ff;
               mul_cmd.mplier = pbsc_pkg::ALPHA_ONE - a_ff;
               state_in      = ST_WAITB;
            end
         end
         ST_WAITB: begin
            if (mul_sts.done) begin
               ema_in   = blend_sum[pbsc_pkg::ALPHA_FRAC_BITS +: PW];
               state_in = ST_DEV;
            end
         end
         ST_DEV: begin
            neg_in = ema_ff < target_ff;
            if (!seen_ff || !reliable_ff) begin
               dec_in.action         = pbsc_pkg::ACT_PAUSE;
               dec_in.adjust_bps     = '0;
               dec_in.deviation_bps  = '0;
               dec_in.confidence     = seen_ff ? pbsc_pkg::CONF_UNRELIABLE
                                               : pbsc_pkg::CONF_MISSING;
               dec_in.smoothed_price = ema_ff;
               state_in              = ST_OUT;
            end else begin
               state_in = ST_WDEV;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = DW'(ema_ff < target_ff ? target_ff - ema_ff
                                                         : ema_ff - target_ff)
                                  * DW'(10000);
               div_cmd.divisor  = DW'(target_ff);
            end
         end
         ST_WDEV: begin
            if (div_sts.done) begin
               // Zero target divides to all ones, so it is handled apart: saturate unless the deviation is zero.
               if (target_ff == '0) begin
                  mag_in = (abs_dev != '0) ? pbsc_pkg::DEV_SAT : '0;
               end else if (div_sts.quotient > DW'(pbsc_pkg::DEV_SAT)) begin
                  mag_in = pbsc_pkg::DEV_SAT;
               end else begin
                  mag_in = div_sts.quotient[20:0];
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            dec_in.deviation_bps  = neg_ff ? (21'd0 - mag_ff) : mag_ff;
            dec_in.smoothed_price = ema_ff;
            if (mag_ff > 21'(emerg_bps)) begin
               dec_in.action     = neg_ff ? pbsc_pkg::ACT_EMERG_EXPAND
                                          : pbsc_pkg::ACT_EMERG_CONTR;
               dec_in.adjust_bps = {max_adj_ff, 1'b0};
               dec_in.confidence = pbsc_pkg::CONF_EMERGENCY;
               state_in          = ST_OUT;
            end else if (mag_ff > 21'(band_bps) && mag_ff != '0) begin
               dec_in.action     = neg_ff ? pbsc_pkg::ACT_EXPAND : pbsc_pkg::ACT_CONTRACT;
               dec_in.confidence = pbsc_pkg::CONF_ADJUST;
               if (band_bps == '0) begin
                  dec_in.adjust_bps = 15'(max_adj_ff);
                  state_in          = ST_OUT;
               end else begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = DW'(mag_ff) * DW'(max_adj_ff);
                  div_cmd.divisor  = DW'(band_bps);
                  state_in         = ST_WADJ;
               end
            end else begin
               dec_in.action     = pbsc_pkg::ACT_NONE;
               dec_in.adjust_bps = '0;
               dec_in.confidence = pbsc_pkg::CONF_NONE;
               state_in          = ST_OUT;
            end
         end
         ST_WADJ: begin
            if (div_sts.done) begin
               dec_in.adjust_bps = (div_sts.quotient > DW'(max_adj_ff)) ?
                                   15'(max_adj_ff) : div_sts.quotient[14:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_in       = dec_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ema_ff       <= '0;
         ema_valid_ff <= 1'b0;
         seen_ff      <= 1'b0;
         reliable_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ema_ff       <= ema_in;
         ema_valid_ff <= ema_valid_in;
         seen_ff      <= seen_in;
         reliable_ff  <= reliable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      price_ff <= price_in;
      a_ff     <= a_in;
      part_ff  <= part_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      dec_ff   <= dec_in;
      rsp_ff   <= rsp_in;
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> rsp_valid_ff)
      else $error("decision dropped under backpressure");
   a_out_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> $stable(rsp_ff))
      else $error("decision changed under backpressure");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_bus.ready) else $error("request taken while busy");
   a_ema_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(ema_valid_ff) |-> ema_valid_ff) else $error("EMA valid lost");

endmodule : price_band_stability_controller
`default_nettype wire

[bench/price_band_stability_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_band_stability_controller_tb: self-checking bench for the controller
// Drives price and quote beats with random gaps and random response stalls,
// predicts each decision with an independent model of the smoothing and the
// band logic, and compares every response beat in full, printing each field.
// ----------------------------------------------------------------------------
module price_band_stability_controller_tb;

   localparam longint unsigned PMASK = (64'd1 << pbsc_pkg::PRICE_WIDTH) - 1;
   localparam longint unsigned AONE  = 64'd1 << pbsc_pkg::ALPHA_FRAC_BITS;
   localparam longint unsigned AMINV = (AONE + 999) / 1000;
   localparam longint LIMIT_CYCLES   = 2000000;
   localparam int EXP_DEPTH          = 16;
   // An index past the register list; writes to it are ignored.
   localparam logic [pbsc_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [pbsc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [pbsc_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   pbsc_req_if req_ch ();
   pbsc_rsp_if rsp_ch ();

   price_band_stability_controller uut (
      .clock(clock), .reset(reset), .req_bus(req_ch.sink), .rsp_bus(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Configuration and state copies for the decision predictor.
   longint unsigned target_q, band_q, max_adj_q, emerg_q, alpha_q;
   longint unsigned ema_q;
   bit ema_ok, quote_seen_q, quote_ok_q;

   pbsc_pkg::rsp_type exp_mem [0:EXP_DEPTH-1];
   int unsigned exp_wr = 0;
   int unsigned exp_rd = 0;
   int  errors = 0;
   longint cycles = 0;
   bit  stall_enable = 1'b1;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Timeout at %0t", $time);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Response side: random stalls, and checking against the oldest prediction.
   always @(posedge clock) begin
      pbsc_pkg::rsp_type exp_d;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected decision beat %h", $time, rsp_ch.payload);
            errors++;
         end else begin
            exp_d = exp_mem[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (exp_d !== rsp_ch.payload) begin
               $display("%0t: mismatch expected act=%0d adj=%0d dev=%0d conf=%0d ema=%0d",
                        $time, exp_d.action, exp_d.adjust_bps,
                        $signed(exp_d.deviation_bps), exp_d.confidence,
                        exp_d.smoothed_price);
               $display("%0t:          actual   act=%0d adj=%0d dev=%0d conf=%0d ema=%0d",
                        $time, rsp_ch.payload.action, rsp_ch.payload.adjust_bps,
                        $signed(rsp_ch.payload.deviation_bps),
                        rsp_ch.payload.confidence, rsp_ch.payload.smoothed_price);
               errors++;
            end
         end
      end
      if (reset || !stall_enable) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= (gap_len() == 0);
   end

   // floor(d * 10000 / t) in 128-bit arithmetic.
   function automatic longint unsigned bps_quotient(longint unsigned d,
                                                     longint unsigned t);
      logic [127:0] num;
      num = 128'(d) * 128'd10000;
      return 64'(num / 128'(t));
   endfunction

   function automatic pbsc_pkg::rsp_type predict_decision(pbsc_pkg::req_type it);
      pbsc_pkg::rsp_type r;
      longint unsigned a, d, mag, band_bps, adj;
      logic [127:0] mix;
      bit neg;
      r = '0;
      if (!ema_ok) begin
         ema_q = 64'(it.price);
         ema_ok = 1'b1;
      end else begin
         a = alpha_q;
         if (a < AMINV) a = AMINV;
         if (a > AONE) a = AONE;
         mix = 128'(a) * 128'(it.price) + 128'(AONE - a) * 128'(ema_q);
         ema_q = 64'(mix >> pbsc_pkg::ALPHA_FRAC_BITS) & PMASK;
      end
      if (it.func) begin
         quote_seen_q = 1'b1;
         quote_ok_q = (it.spread_bps < pbsc_pkg::SPREAD_LIMIT) &&
                      (it.avg_confidence >= pbsc_pkg::CONF_THRESHOLD) &&
                      (it.source_count >= pbsc_pkg::SOURCE_MIN);
      end
      if (!quote_seen_q) begin
         r.action = pbsc_pkg::ACT_PAUSE;
         r.confidence = pbsc_pkg::CONF_MISSING;
      end else if (!quote_ok_q) begin
         r.action = pbsc_pkg::ACT_PAUSE;
         r.confidence = pbsc_pkg::CONF_UNRELIABLE;
      end else begin
         neg = ema_q < target_q;
         d = neg ? target_q - ema_q : ema_q - target_q;
         band_bps = band_q * 100;
         if (target_q == 0) mag = (d > 0) ? 1000000 : 0;
         else if (d / 100 >= target_q) mag = 1000000;
         else mag = bps_quotient(d, target_q);
         r.deviation_bps = neg ? pbsc_pkg::DEV_WIDTH'(-mag) : pbsc_pkg::DEV_WIDTH'(mag);
         if (mag > emerg_q * 100) begin
            r.action = neg ? pbsc_pkg::ACT_EMERG_EXPAND : pbsc_pkg::ACT_EMERG_CONTR;
            r.adjust_bps = pbsc_pkg::ADJ_WIDTH'(max_adj_q * 2);
            r.confidence = pbsc_pkg::CONF_EMERGENCY;
         end else if (mag > band_bps && mag != 0) begin
            r.action = neg ? pbsc_pkg::ACT_EXPAND : pbsc_pkg::ACT_CONTRACT;
            if (band_bps == 0) adj = max_adj_q;
            else begin
               adj = mag * max_adj_q / band_bps;
               if (adj > max_adj_q) adj = max_adj_q;
            end
            r.adjust_bps = pbsc_pkg::ADJ_WIDTH'(adj);
            r.confidence = pbsc_pkg::CONF_ADJUST;
         end else begin
            r.action = pbsc_pkg::ACT_NONE;
            r.confidence = pbsc_pkg::CONF_NONE;
         end
      end
      r.smoothed_price = ema_q[pbsc_pkg::PRICE_WIDTH-1:0];
      return r;
   endfunction

   // Valid stays high into a gap-free next beat; it drops only before a gap
   // or when the sequence is drained.
   task automatic send_price(pbsc_pkg::req_type it);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.payload <= it;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      exp_mem[exp_wr % EXP_DEPTH] = predict_decision(it);
      exp_wr++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(logic [pbsc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [pbsc_pkg::CSR_DATA_WIDTH-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         pbsc_pkg::CSR_TARGET:    target_q  = val & PMASK;
         pbsc_pkg::CSR_BAND:      band_q    = val & 64'h7F;
         pbsc_pkg::CSR_MAX_ADJ:   max_adj_q = val & 64'h3FFF;
         pbsc_pkg::CSR_EMERGENCY: emerg_q   = val & 64'h7F;
         pbsc_pkg::CSR_ALPHA:     alpha_q   = val & ((64'd1 << pbsc_pkg::ALPHA_WIDTH) - 1);
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic pbsc_pkg::req_type make_item(bit f, longint unsigned p, int sp,
                                                   int cf, int sc);
      pbsc_pkg::req_type it;
      it.func = f;
      it.price = p[pbsc_pkg::PRICE_WIDTH-1:0];
      it.spread_bps = sp[15:0];
      it.avg_confidence = cf[6:0];
      it.source_count = sc[7:0];
      return it;
   endfunction

   // Prices clustered around the target so all decision regions are hit.
   function automatic pbsc_pkg::req_type random_item();
      pbsc_pkg::req_type it;
      longint unsigned p, spanv;
      int r;
      r = $urandom_range(0, 99);
      spanv = (target_q / 3) + 1;
      if (r < 10) p = {$urandom, $urandom} & PMASK;
      else if (r < 15) p = 64'($urandom_range(0, 3));
      else begin
         p = target_q + ({$urandom, $urandom} % (2 * spanv)) - spanv;
         p = p & PMASK;
      end
      it = make_item($urandom_range(0, 2) == 0, p, 0, 0, 0);
      if ($urandom_range(0, 3) != 0) begin
         it.spread_bps = 16'($urandom_range(0, 230));
         it.avg_confidence = 7'($urandom_range(60, 100));
         it.source_count = 8'($urandom_range(0, 8));
      end else begin
         it.spread_bps = 16'($urandom);
         it.avg_confidence = 7'($urandom);
         it.source_count = 8'($urandom);
      end
      return it;
   endfunction

   task automatic test_missing_and_quality();
      send_price(make_item(1'b0, 100000, 0, 0, 0));
      send_price(make_item(1'b0, PMASK, 16'hFFFF, 127, 255));
      send_price(make_item(1'b1, 98000, 200, 70, 3));
      send_price(make_item(1'b1, 98000, 199, 69, 3));
      send_price(make_item(1'b1, 98000, 199, 70, 2));
      send_price(make_item(1'b1, 100000, 199, 70, 3));
      send_price(make_item(1'b0, 0, 0, 0, 0));
      send_price(make_item(1'b1, 250000, 0, 100, 255));
      send_price(make_item(1'b1, PMASK, 199, 127, 255));
      wait_drained();
   endtask

   task automatic test_register_extremes();
      write_reg(pbsc_pkg::CSR_ALPHA, 40'd0);
      write_reg(pbsc_pkg::CSR_BAND, 40'd0);
      write_reg(pbsc_pkg::CSR_EMERGENCY, 40'd127);
      write_reg(pbsc_pkg::CSR_MAX_ADJ, 40'h3FFF);
      write_reg(pbsc_pkg::CSR_TARGET, 40'd0);
      write_reg(CSR_UNUSED, 40'hFF_FFFF_FFFF);
      send_price(make_item(1'b1, 5, 0, 100, 10));
      send_price(make_item(1'b1, 0, 0, 100, 10));
      wait_drained();
      write_reg(pbsc_pkg::CSR_TARGET, 40'(PMASK));
      write_reg(pbsc_pkg::CSR_ALPHA, 40'h1FFFF);
      send_price(make_item(1'b1, 0, 0, 100, 10));
      send_price(make_item(1'b1, PMASK, 0, 100, 10));
      wait_drained();
      write_reg(pbsc_pkg::CSR_TARGET, 40'd1);
      write_reg(pbsc_pkg::CSR_BAND, 40'd127);
      write_reg(pbsc_pkg::CSR_EMERGENCY, 40'd0);
      write_reg(pbsc_pkg::CSR_ALPHA, 40'd65536);
      send_price(make_item(1'b1, 1, 0, 100, 10));
      send_price(make_item(1'b1, 2, 0, 100, 10));
      send_price(make_item(1'b1, 0, 0, 100, 10));
      wait_drained();
   endtask

   task automatic test_random_settings();
      int ph, k;
      for (ph = 0; ph < 10; ph++) begin
         stall_enable = (ph % 4 != 3);
         write_reg(pbsc_pkg::CSR_TARGET, (ph == 0) ? 40'd100000 :
                   (ph == 9) ? 40'(PMASK) :
                   40'({$urandom, $urandom} >> $urandom_range(24, 63)) + 40'd1);
         write_reg(pbsc_pkg::CSR_BAND,
                   (ph == 1) ? 40'd0 : 40'($urandom_range(0, 100)));
         write_reg(pbsc_pkg::CSR_MAX_ADJ,
                   (ph == 2) ? 40'd10000 : 40'($urandom_range(0, 16383)));
         write_reg(pbsc_pkg::CSR_EMERGENCY,
                   (ph == 3) ? 40'd100 : 40'($urandom_range(0, 127)));
         write_reg(pbsc_pkg::CSR_ALPHA,
                   (ph == 4) ? 40'd66 : 40'($urandom_range(0, 131071)));
         for (k = 0; k < 85; k++) send_price(random_item());
         wait_drained();
      end
      stall_enable = 1'b1;
   endtask

   initial begin
      target_q = 100000; band_q = 5; max_adj_q = 100; emerg_q = 20; alpha_q = 6554;
      ema_q = 0; ema_ok = 0; quote_seen_q = 0; quote_ok_q = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_missing_and_quality();
      test_register_extremes();
      test_random_settings();
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

[sim.f]
src/pbsc_pkg.sv
src/pbsc_if.sv
src/pbsc_mul.sv
src/pbsc_div.sv
src/price_band_stability_controller.sv
bench/price_band_stability_controller_tb.sv
